FILE: rtl/rkgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkgd_pkg
// shared types and constants for the rotary knob gesture detector
// ----------------------------------------------------------------------------
package rkgd_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  localparam logic [CFG_W-1:0] DOUBLE_CLICK_WINDOW_RESET  = 16'd500;
  localparam logic [CFG_W-1:0] SINGLE_CLICK_TIMEOUT_RESET = 16'd300;
  localparam logic [CFG_W-1:0] HOLD_THRESHOLD_RESET       = 16'd1000;

  typedef enum logic [IDX_W-1:0] {
    REG_DOUBLE_CLICK_WINDOW  = 2'd0,
    REG_SINGLE_CLICK_TIMEOUT = 2'd1,
    REG_HOLD_THRESHOLD       = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [CFG_W-1:0] double_click_window_ms;
    logic [CFG_W-1:0] single_click_timeout_ms;
    logic [CFG_W-1:0] hold_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]       now_ms;
    logic                    position_changed;
    logic signed [POS_W-1:0] knob_position;
    logic                    click_seen;
    logic                    button_level;
  } item_t;

  typedef struct packed {
    logic turn_left;
    logic turn_right;
    logic single_click;
    logic double_click;
    logic pressed;
    logic held;
  } result_t;

endpackage

FILE: rtl/rkgd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkgd_cfg
// timing register file, written through the configuration channel
// ----------------------------------------------------------------------------
module rkgd_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rkgd_pkg::IDX_W-1:0]      cfg_index,
  input  logic [rkgd_pkg::CFG_W-1:0]      cfg_data,
  output rkgd_pkg::cfg_t                  cfg
);

  rkgd_pkg::cfg_t regs;

  assign cfg_ready = 1'b1;
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.double_click_window_ms  <= rkgd_pkg::DOUBLE_CLICK_WINDOW_RESET;
      regs.single_click_timeout_ms <= rkgd_pkg::SINGLE_CLICK_TIMEOUT_RESET;
      regs.hold_limit_ms           <= rkgd_pkg::HOLD_THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (rkgd_pkg::cfg_index_t'(cfg_index))
        rkgd_pkg::REG_DOUBLE_CLICK_WINDOW:  regs.double_click_window_ms  <= cfg_data;
        rkgd_pkg::REG_SINGLE_CLICK_TIMEOUT: regs.single_click_timeout_ms <= cfg_data;
        rkgd_pkg::REG_HOLD_THRESHOLD:       regs.hold_limit_ms           <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: rtl/rkgd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rkgd_core
// gesture state and per-step decision logic
// ----------------------------------------------------------------------------
module rkgd_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  rkgd_pkg::item_t   item,
  input  rkgd_pkg::cfg_t    cfg,
  output rkgd_pkg::result_t result
);

  logic signed [rkgd_pkg::POS_W-1:0] last_position;
  logic [rkgd_pkg::TIME_W-1:0]       last_click_time;
  logic                              awaiting_second_click;
  logic [rkgd_pkg::TIME_W-1:0]       press_start_time;
  logic                              was_pressed;
  logic                              hold_active;

  logic [rkgd_pkg::TIME_W-1:0]       last_click_time_next;
  logic                              awaiting_second_click_next;
  logic [rkgd_pkg::TIME_W-1:0]       press_start_time_next;
  logic                              hold_active_next;

  logic [rkgd_pkg::TIME_W-1:0]       click_elapsed;
  logic [rkgd_pkg::TIME_W-1:0]       press_elapsed;
  logic                              is_left;
  logic                              single_hit;
  logic                              double_hit;

  assign click_elapsed = item.now_ms - last_click_time;
  assign press_start_time_next = (item.button_level && !was_pressed) ? item.now_ms
                                                                      : press_start_time;
  assign press_elapsed = item.now_ms - press_start_time_next;
  assign is_left = $signed(last_position) > $signed(item.knob_position);

  always_comb begin
    last_click_time_next       = last_click_time;
    awaiting_second_click_next = awaiting_second_click;
    single_hit                 = 1'b0;
    double_hit                 = 1'b0;
    if (item.click_seen) begin
      if (!hold_active) begin
        if ((click_elapsed > {16'd0, cfg.double_click_window_ms}) &&
            !awaiting_second_click) begin
          last_click_time_next       = item.now_ms;
          awaiting_second_click_next = 1'b1;
        end else begin
          awaiting_second_click_next = 1'b0;
          double_hit                 = 1'b1;
        end
      end
    end else if (awaiting_second_click &&
                 (click_elapsed > {16'd0, cfg.single_click_timeout_ms})) begin
      awaiting_second_click_next = 1'b0;
      single_hit                 = 1'b1;
    end
  end

  always_comb begin
    if (item.button_level) begin
      hold_active_next = hold_active ||
                         (press_elapsed > {16'd0, cfg.hold_limit_ms});
    end else begin
      hold_active_next = 1'b0;
    end
  end

  always_comb begin
    result.turn_left    = item.position_changed && is_left;
    result.turn_right   = item.position_changed && !is_left;
    result.single_click = single_hit;
    result.double_click = double_hit;
    result.pressed      = item.button_level;
    result.held         = hold_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_position         <= '0;
      last_click_time       <= '0;
      awaiting_second_click <= 1'b0;
      press_start_time      <= '0;
      was_pressed           <= 1'b0;
      hold_active           <= 1'b0;
    end else if (step) begin
      if (item.position_changed) begin
        last_position <= item.knob_position;
      end
      last_click_time       <= last_click_time_next;
      awaiting_second_click <= awaiting_second_click_next;
      press_start_time      <= press_start_time_next;
      was_pressed           <= item.button_level;
      hold_active           <= hold_active_next;
    end
  end

  a_held_needs_level: assert property (@(posedge clk) disable iff (rst)
    result.held |-> item.button_level)
    else $error("hold reported without button down");

  a_release_clears_hold: assert property (@(posedge clk) disable iff (rst)
    (step && !item.button_level) |=> (!hold_active && !was_pressed))
    else $error("release did not clear press state");

  a_click_while_hold_ignored: assert property (@(posedge clk) disable iff (rst)
    (step && item.click_seen && hold_active) |=>
      ($stable(awaiting_second_click) && $stable(last_click_time)))
    else $error("click changed state while holding");

endmodule

FILE: rtl/rotary_knob_gesture_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_knob_gesture_detector_top
// turn, click, double click and hold detection on polled knob samples
// ----------------------------------------------------------------------------
// path: an accepted transaction passes through the input register, then the result
//   register holding the decision of the gesture logic, before out_valid rises
// throughput: one transaction per cycle, limited only by out_ready
// reset: synchronous; clears both pipeline valid flags and gesture state and
//   loads the timing registers with 500 / 300 / 1000 ms
// ----------------------------------------------------------------------------
module rotary_knob_gesture_detector_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rkgd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [rkgd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rkgd_pkg::TIME_W-1:0]       now_ms,
  input  logic                              position_changed,
  input  logic signed [rkgd_pkg::POS_W-1:0] knob_position,
  input  logic                              click_seen,
  input  logic                              button_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              turn_left,
  output logic                              turn_right,
  output logic                              single_click,
  output logic                              double_click,
  output logic                              pressed,
  output logic                              held
);

  rkgd_pkg::cfg_t    cfg;
  rkgd_pkg::item_t   item;
  rkgd_pkg::result_t step_result;
  rkgd_pkg::result_t result;
  logic              item_valid;
  logic              advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  rkgd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rkgd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .cfg    (cfg),
    .result (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item.now_ms           <= now_ms;
      item.position_changed <= position_changed;
      item.knob_position    <= knob_position;
      item.click_seen       <= click_seen;
      item.button_level     <= button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= item_valid;
    end
    if (advance) begin
      result <= step_result;
    end
  end

  assign turn_left    = result.turn_left;
  assign turn_right   = result.turn_right;
  assign single_click = result.single_click;
  assign double_click = result.double_click;
  assign pressed      = result.pressed;
  assign held         = result.held;

  a_turn_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(turn_left && turn_right))
    else $error("left and right turn in one result");

  a_click_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(single_click && double_click))
    else $error("single and double click in one result");

  a_held_implies_pressed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && held) |-> pressed)
    else $error("held without pressed");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !advance) |=> item_valid)
    else $error("stalled transaction dropped");

endmodule
